/* rtl/string_literal_decoder_defines.svh */
// ----------------------------------------------------------------------------
// String literal decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STRING_LITERAL_DECODER_DEFINES_SVH
`define STRING_LITERAL_DECODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/sld_pkg.sv */
// ----------------------------------------------------------------------------
// String literal decoder package
// Types, character codes and small helper functions shared by the decoder.
// ----------------------------------------------------------------------------
package sld_pkg;

	localparam int CP_W = 21;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BODY,
		PH_ESC,
		PH_HEX,
		PH_CLOSING
	} phase_t;

	typedef enum logic [1:0] {
		MODE_CHAR,
		MODE_START,
		MODE_END
	} mode_t;

	typedef enum logic [2:0] {
		EV_CHAR,
		EV_STRING,
		EV_RUNE,
		EV_QUOTE_IDENT,
		EV_BAD_ESC,
		EV_BAD_HEX,
		EV_UNTERM
	} ev_t;

	localparam logic [CP_W-1:0] CP_TAB    = 21'd9;
	localparam logic [CP_W-1:0] CP_LF     = 21'd10;
	localparam logic [CP_W-1:0] CP_CR     = 21'd13;
	localparam logic [CP_W-1:0] CP_SPACE  = 21'd32;
	localparam logic [CP_W-1:0] CP_DQUOTE = 21'd34;
	localparam logic [CP_W-1:0] CP_SQUOTE = 21'd39;
	localparam logic [CP_W-1:0] CP_RPAREN = 21'd41;
	localparam logic [CP_W-1:0] CP_COMMA  = 21'd44;
	localparam logic [CP_W-1:0] CP_ZERO   = 21'd48;
	localparam logic [CP_W-1:0] CP_NINE   = 21'd57;
	localparam logic [CP_W-1:0] CP_UC_A   = 21'd65;
	localparam logic [CP_W-1:0] CP_UC_F   = 21'd70;
	localparam logic [CP_W-1:0] CP_UC_U   = 21'd85;
	localparam logic [CP_W-1:0] CP_UC_X   = 21'd88;
	localparam logic [CP_W-1:0] CP_BSLASH = 21'd92;
	localparam logic [CP_W-1:0] CP_RBRACK = 21'd93;
	localparam logic [CP_W-1:0] CP_LC_A   = 21'd97;
	localparam logic [CP_W-1:0] CP_LC_F   = 21'd102;
	localparam logic [CP_W-1:0] CP_LC_N   = 21'd110;
	localparam logic [CP_W-1:0] CP_LC_R   = 21'd114;
	localparam logic [CP_W-1:0] CP_LC_T   = 21'd116;
	localparam logic [CP_W-1:0] CP_LC_U   = 21'd117;
	localparam logic [CP_W-1:0] CP_LC_X   = 21'd120;

	localparam logic [2:0] HEX_LEN_X = 3'd2;
	localparam logic [2:0] HEX_LEN_U = 3'd4;

	typedef struct packed {
		phase_t      phase;
		logic        delim_double;
		logic        long_lit;
		logic [15:0] hex_acc;
		logic [2:0]  hex_left;
		logic [1:0]  len_seen;
		logic [1:0]  quote_run;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase: PH_IDLE, delim_double: 1'b0, long_lit: 1'b0, hex_acc: 16'd0,
		hex_left: 3'd0, len_seen: 2'd0, quote_run: 2'd0
	};

	typedef struct packed {
		logic [CP_W-1:0] value;
		ev_t             ev;
		logic            gave_back;
		logic            last;
	} res_t;

	// Results of one transaction; count entries starting at res[0] are valid.
	typedef struct packed {
		logic [1:0]      count;
		res_t [2:0]      res;
	} bundle_t;

	function automatic res_t mk_res(logic [CP_W-1:0] v, ev_t e, logic gb);
		res_t r;
		r.value     = v;
		r.ev        = e;
		r.gave_back = gb;
		r.last      = 1'b0;
		return r;
	endfunction

	function automatic ev_t end_ev(logic [1:0] len);
		return (len == 2'd1) ? EV_RUNE : EV_STRING;
	endfunction

	function automatic logic [CP_W-1:0] delim(logic dbl);
		return dbl ? CP_DQUOTE : CP_SQUOTE;
	endfunction

	// Bit 4 flags a non-hex character; bits 3:0 hold the digit.
	function automatic logic [4:0] hex_digit(logic [CP_W-1:0] c);
		logic [CP_W-1:0] t;
		t = '0;
		if (c >= CP_ZERO && c <= CP_NINE) begin
			t = c - CP_ZERO;
			return {1'b0, t[3:0]};
		end
		if (c >= CP_LC_A && c <= CP_LC_F) begin
			t = c - CP_LC_A + 21'd10;
			return {1'b0, t[3:0]};
		end
		if (c >= CP_UC_A && c <= CP_UC_F) begin
			t = c - CP_UC_A + 21'd10;
			return {1'b0, t[3:0]};
		end
		return 5'b10000;
	endfunction

	function automatic logic ends_ident(logic [CP_W-1:0] c);
		return c == CP_RPAREN || c == CP_RBRACK || c == CP_SPACE ||
			c == CP_COMMA || c == CP_TAB || c == CP_LF;
	endfunction

endpackage

/* rtl/sld_step.sv */
// ----------------------------------------------------------------------------
// String literal decoder step logic
// Computes the next decoder state and the results of one transaction.
// ----------------------------------------------------------------------------
module sld_step (
	input  sld_pkg::state_t               st,
	input  logic [1:0]                    mode,
	input  logic [sld_pkg::CP_W-1:0]      code_point,
	input  logic                          quote_double,
	input  logic                          long_form,
	output sld_pkg::state_t               st_nxt,
	output sld_pkg::bundle_t              bundle
);

	always_comb begin
		logic [1:0]               k;
		logic [sld_pkg::CP_W-1:0] d;
		logic [4:0]               hx;
		logic [15:0]              acc;

		st_nxt = st;
		bundle = '0;
		k      = 2'd0;
		d      = sld_pkg::delim(st.delim_double);
		hx     = sld_pkg::hex_digit(code_point);
		acc    = {st.hex_acc[11:0], hx[3:0]};

		unique case (sld_pkg::mode_t'(mode))
			sld_pkg::MODE_START: begin
				if (st.phase == sld_pkg::PH_CLOSING) begin
					bundle.res[k] = sld_pkg::mk_res('0, sld_pkg::end_ev(st.len_seen), 1'b0);
					k = k + 2'd1;
				end
				st_nxt              = sld_pkg::STATE_RESET;
				st_nxt.delim_double = quote_double;
				st_nxt.long_lit     = long_form;
				st_nxt.phase        = sld_pkg::PH_BODY;
			end
			sld_pkg::MODE_END: begin
				if (st.phase == sld_pkg::PH_CLOSING) begin
					bundle.res[k] = sld_pkg::mk_res('0, sld_pkg::end_ev(st.len_seen), 1'b0);
					k = k + 2'd1;
				end else if (st.phase != sld_pkg::PH_IDLE) begin
					bundle.res[k] = sld_pkg::mk_res('0, sld_pkg::EV_UNTERM, 1'b0);
					k = k + 2'd1;
				end
				st_nxt.phase     = sld_pkg::PH_IDLE;
				st_nxt.quote_run = 2'd0;
			end
			sld_pkg::MODE_CHAR: begin
				unique case (st.phase)
					sld_pkg::PH_BODY: begin
						if (code_point == d) begin
							if (!st.long_lit) begin
								bundle.res[k] = sld_pkg::mk_res('0,
									sld_pkg::end_ev(st.len_seen), 1'b0);
								k = k + 2'd1;
								st_nxt.phase = sld_pkg::PH_IDLE;
							end else if (st.quote_run == 2'd2) begin
								st_nxt.quote_run = 2'd0;
								st_nxt.phase     = sld_pkg::PH_CLOSING;
							end else begin
								st_nxt.quote_run = st.quote_run + 2'd1;
							end
						end else begin
							// flush pending delimiters as content
							for (int i = 0; i < 2; i++) begin
								if (2'(i) < st.quote_run) begin
									bundle.res[k] = sld_pkg::mk_res(d, sld_pkg::EV_CHAR, 1'b0);
									k = k + 2'd1;
									if (st_nxt.len_seen != 2'd2)
										st_nxt.len_seen = st_nxt.len_seen + 2'd1;
								end
							end
							st_nxt.quote_run = 2'd0;
							if (!st.delim_double && st_nxt.len_seen == 2'd1 &&
								sld_pkg::ends_ident(code_point)) begin
								bundle.res[k] = sld_pkg::mk_res('0, sld_pkg::EV_QUOTE_IDENT,
									1'b1);
								k = k + 2'd1;
								st_nxt.phase = sld_pkg::PH_IDLE;
							end else if (code_point == sld_pkg::CP_BSLASH) begin
								st_nxt.phase = sld_pkg::PH_ESC;
							end else begin
								bundle.res[k] = sld_pkg::mk_res(code_point, sld_pkg::EV_CHAR,
									1'b0);
								k = k + 2'd1;
								if (st_nxt.len_seen != 2'd2)
									st_nxt.len_seen = st_nxt.len_seen + 2'd1;
							end
						end
					end
					sld_pkg::PH_ESC: begin
						st_nxt.phase = sld_pkg::PH_BODY;
						unique case (code_point) inside
							sld_pkg::CP_LC_N, sld_pkg::CP_LC_R, sld_pkg::CP_LC_T,
							sld_pkg::CP_BSLASH, sld_pkg::CP_ZERO: begin
								if (code_point == sld_pkg::CP_LC_N)
									bundle.res[k] = sld_pkg::mk_res(sld_pkg::CP_LF,
										sld_pkg::EV_CHAR, 1'b0);
								else if (code_point == sld_pkg::CP_LC_R)
									bundle.res[k] = sld_pkg::mk_res(sld_pkg::CP_CR,
										sld_pkg::EV_CHAR, 1'b0);
								else if (code_point == sld_pkg::CP_LC_T)
									bundle.res[k] = sld_pkg::mk_res(sld_pkg::CP_TAB,
										sld_pkg::EV_CHAR, 1'b0);
								else if (code_point == sld_pkg::CP_BSLASH)
									bundle.res[k] = sld_pkg::mk_res(sld_pkg::CP_BSLASH,
										sld_pkg::EV_CHAR, 1'b0);
								else
									bundle.res[k] = sld_pkg::mk_res('0, sld_pkg::EV_CHAR,
										1'b0);
								k = k + 2'd1;
								if (st_nxt.len_seen != 2'd2)
									st_nxt.len_seen = st_nxt.len_seen + 2'd1;
							end
							sld_pkg::CP_LC_X, sld_pkg::CP_UC_X: begin
								st_nxt.phase    = sld_pkg::PH_HEX;
								st_nxt.hex_acc  = 16'd0;
								st_nxt.hex_left = sld_pkg::HEX_LEN_X;
							end
							sld_pkg::CP_LC_U, sld_pkg::CP_UC_U: begin
								st_nxt.phase    = sld_pkg::PH_HEX;
								st_nxt.hex_acc  = 16'd0;
								st_nxt.hex_left = sld_pkg::HEX_LEN_U;
							end
							default: begin
								st_nxt.phase  = sld_pkg::PH_IDLE;
								bundle.res[k] = sld_pkg::mk_res('0, sld_pkg::EV_BAD_ESC, 1'b0);
								k = k + 2'd1;
							end
						endcase
					end
					sld_pkg::PH_HEX: begin
						if (hx[4]) begin
							st_nxt.phase  = sld_pkg::PH_IDLE;
							bundle.res[k] = sld_pkg::mk_res('0, sld_pkg::EV_BAD_HEX, 1'b0);
							k = k + 2'd1;
						end else begin
							st_nxt.hex_acc = acc;
							if (st.hex_left != 3'd0)
								st_nxt.hex_left = st.hex_left - 3'd1;
							if (st_nxt.hex_left == 3'd0) begin
								st_nxt.phase  = sld_pkg::PH_BODY;
								bundle.res[k] = sld_pkg::mk_res({5'd0, acc}, sld_pkg::EV_CHAR,
									1'b0);
								k = k + 2'd1;
								if (st_nxt.len_seen != 2'd2)
									st_nxt.len_seen = st_nxt.len_seen + 2'd1;
							end
						end
					end
					sld_pkg::PH_CLOSING: begin
						if (code_point == d) begin
							// fourth delimiter is content
							bundle.res[k] = sld_pkg::mk_res(code_point, sld_pkg::EV_CHAR, 1'b0);
							k = k + 2'd1;
							if (st_nxt.len_seen != 2'd2)
								st_nxt.len_seen = st_nxt.len_seen + 2'd1;
							bundle.res[k] = sld_pkg::mk_res('0,
								sld_pkg::end_ev(st_nxt.len_seen), 1'b0);
							k = k + 2'd1;
						end else begin
							bundle.res[k] = sld_pkg::mk_res('0,
								sld_pkg::end_ev(st.len_seen), 1'b1);
							k = k + 2'd1;
						end
						st_nxt.phase = sld_pkg::PH_IDLE;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase

		bundle.count = k;
		if (k != 2'd0)
			bundle.res[k - 2'd1].last = 1'b1;
	end

endmodule

/* rtl/sld_res_fifo.sv */
// ----------------------------------------------------------------------------
// String literal decoder result queue
// Takes up to three results in one cycle and hands out one per cycle while the reader does not stall.
// ----------------------------------------------------------------------------
module sld_res_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [1:0]             wr_count,
	input  sld_pkg::res_t [2:0]    wr_data,
	output logic                   room,
	output logic                   rd_valid,
	input  logic                   rd_stall,
	output sld_pkg::res_t          rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sld_pkg::res_t [DEPTH-1:0] mem_q;
	logic [PTR_W-1:0]          wr_ptr_q;
	logic [PTR_W-1:0]          rd_ptr_q;
	logic [CNT_W-1:0]          count_q;
	logic                      pop;
	logic [CNT_W-1:0]          push_n;

	function automatic logic [PTR_W-1:0] wrap_add(logic [PTR_W-1:0] p, logic [1:0] off);
		logic [PTR_W+1:0] s;
		s = {2'b00, p} + {{PTR_W{1'b0}}, off};
		if (s >= (PTR_W + 2)'(DEPTH))
			s = s - (PTR_W + 2)'(DEPTH);
		return s[PTR_W-1:0];
	endfunction

	assign push_n   = wr_en ? CNT_W'(wr_count) : '0;
	assign rd_valid = (count_q != '0);
	assign pop      = rd_valid && !rd_stall;
	assign rd_data  = mem_q[rd_ptr_q];
	assign room     = ({1'b0, count_q} + (CNT_W + 1)'(wr_count)) <= (CNT_W + 1)'(DEPTH);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (wr_en && 2'(i) < wr_count)
				mem_q[wrap_add(wr_ptr_q, 2'(i))] <= wr_data[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wrap_add(wr_ptr_q, wr_count);
			if (pop)
				rd_ptr_q <= wrap_add(rd_ptr_q, 2'd1);
			count_q <= count_q + push_n - CNT_W'(pop);
		end
	end

endmodule

/* rtl/string_literal_decoder.sv */
// ----------------------------------------------------------------------------
// String literal decoder
// Decodes escapes in the body of a quoted literal and reports how it ended.
// ----------------------------------------------------------------------------
// A transaction is registered, decoded combinationally and its results (zero
// to three) go into a result queue of RES_DEPTH entries. A transaction moves
// from the input register into the queue, and the queue offers its results on
// the result port. The block takes one transaction per cycle as long as each
// gives at most one result and the result port is not stalled. The result
// port hands out one result per cycle while it is not stalled, so the results
// of a transaction leave it one after another. A transaction waits in the
// input register until the queue has room for all of its results; a result
// leaving in that same cycle is not counted as room.
// ----------------------------------------------------------------------------
`include "string_literal_decoder_defines.svh"

module string_literal_decoder #(
	parameter int RES_DEPTH = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  logic [1:0]                mode,
	input  logic [sld_pkg::CP_W-1:0]  code_point,
	input  logic                      quote_double,
	input  logic                      long_form,
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic [sld_pkg::CP_W-1:0]  value,
	output logic [2:0]                event_res,
	output logic                      gave_back,
	output logic                      last
);

	logic                     valid_s1;
	logic [1:0]               mode_s1;
	logic [sld_pkg::CP_W-1:0] cp_s1;
	logic                     qd_s1;
	logic                     lf_s1;
	sld_pkg::state_t          st_q;
	sld_pkg::state_t          st_nxt;
	sld_pkg::bundle_t         bundle;
	sld_pkg::res_t            head;
	logic                     room;
	logic                     commit;
	logic                     take;

	assign commit     = valid_s1 && room;
	assign item_stall = valid_s1 && !commit;
	assign take       = item_valid && !item_stall;

	always_ff @(posedge clk) begin
		if (take) begin
			mode_s1 <= mode;
			cp_s1   <= code_point;
			qd_s1   <= quote_double;
			lf_s1   <= long_form;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q     <= sld_pkg::STATE_RESET;
		end else begin
			if (take)
				valid_s1 <= 1'b1;
			else if (commit)
				valid_s1 <= 1'b0;
			if (commit)
				st_q <= st_nxt;
		end
	end

	sld_step u_step (
		.st           (st_q),
		.mode         (mode_s1),
		.code_point   (cp_s1),
		.quote_double (qd_s1),
		.long_form    (lf_s1),
		.st_nxt       (st_nxt),
		.bundle       (bundle)
	);

	sld_res_fifo #(
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (commit),
		.wr_count (bundle.count),
		.wr_data  (bundle.res),
		.room     (room),
		.rd_valid (res_valid),
		.rd_stall (res_stall),
		.rd_data  (head)
	);

	assign value     = head.value;
	assign event_res = head.ev;
	assign gave_back = head.gave_back;
	assign last      = head.last;

	`SLD_ASSERT_NOW(a_stall_needs_item, item_stall, valid_s1, "stall without a held transaction")
	`SLD_ASSERT_NOW(a_last_marked, commit && bundle.count != 2'd0, bundle.res[bundle.count - 2'd1].last, "last result of a transaction not marked")
	`SLD_ASSERT_NOW(a_event_value_zero, res_valid && head.ev != sld_pkg::EV_CHAR, head.value == '0, "end or error result carries a value")
	`SLD_ASSERT_NEXT(a_end_goes_idle, commit && mode_s1 == sld_pkg::MODE_END, st_q.phase == sld_pkg::PH_IDLE && st_q.quote_run == 2'd0, "source end did not close the literal")

endmodule
